@@ rtl/rdws_pkg.sv @@
// Shared types, constants and helpers for the DDR read window search.
`default_nettype none

package rdws_pkg;

   localparam int HITS_W      = 8;
   localparam int PASS_W      = 9;
   localparam int DELAY_W     = 2;
   localparam int SEL_W       = 4;   // search select counter, wide enough for 16 selects
   localparam int SEL_OUT_W   = 3;
   localparam int RUN_W       = 4;
   localparam int TIMING_W    = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   localparam logic [PASS_W-1:0]  PASS_TOTAL_RST  = 9'd360;
   localparam logic [DELAY_W-1:0] START_DELAY_RST = 2'd3;
   localparam logic [RUN_W-1:0]   RUN_MAX         = 4'd15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PASS_TOTAL  = 1'b0,
      CSR_START_DELAY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PASS_W-1:0]  pass_total;
      logic [DELAY_W-1:0] start_delay;
   } cfg_type;

   typedef struct packed {
      logic [DELAY_W-1:0] cur_delay;
      logic [SEL_W-1:0]   cur_select;
      logic [RUN_W-1:0]   run_length;
      logic               window_found;
      logic [DELAY_W-1:0] best_delay;
      logic [SEL_W-1:0]   best_select;
      logic               search_done;
   } search_state_type;

   typedef struct packed {
      logic [DELAY_W-1:0]   trial_read_delay;
      logic [SEL_OUT_W-1:0] trial_clock_select;
      logic [TIMING_W-1:0]  timing_word;
      logic                 done_res;
      logic                 found;
      logic [DELAY_W-1:0]   chosen_read_delay;
      logic [SEL_OUT_W-1:0] chosen_clock_select;
   } result_type;

   // Clamp the programmed start delay to the last delay that exists.
   function automatic logic [DELAY_W-1:0] clamp_delay(logic [DELAY_W-1:0] start,
                                                      int unsigned num_delays);
      logic [DELAY_W-1:0] d;
      d = start;
      if (32'(start) >= num_delays) d = DELAY_W'(num_delays - 1);
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/rdws_if.sv @@
// Request and response channel interfaces for the DDR read window search.
`default_nettype none

interface rdws_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [rdws_pkg::HITS_W-1:0]    burst_hits;
   logic [rdws_pkg::HITS_W-1:0]    valid_count;

   modport source (output valid, action, burst_hits, valid_count, input ready);
   modport sink   (input valid, action, burst_hits, valid_count, output ready);
endinterface

interface rdws_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rdws_pkg::DELAY_W-1:0]      trial_read_delay;
   logic [rdws_pkg::SEL_OUT_W-1:0]    trial_clock_select;
   logic [rdws_pkg::TIMING_W-1:0]     timing_word;
   logic                              done_res;
   logic                              found;
   logic [rdws_pkg::DELAY_W-1:0]      chosen_read_delay;
   logic [rdws_pkg::SEL_OUT_W-1:0]    chosen_clock_select;

   modport source (output valid, trial_read_delay, trial_clock_select, timing_word,
                   done_res, found, chosen_read_delay, chosen_clock_select,
                   input ready);
   modport sink   (input valid, trial_read_delay, trial_clock_select, timing_word,
                   done_res, found, chosen_read_delay, chosen_clock_select,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/rdws_csr.sv @@
// Configuration registers: pass total and start read delay.
`default_nettype none

module rdws_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [rdws_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rdws_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rdws_pkg::cfg_type                       cfg
);

   rdws_pkg::cfg_type cfg_ff;
   rdws_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (rdws_pkg::csr_index_type'(csr_index))
            rdws_pkg::CSR_PASS_TOTAL: begin
               cfg_in.pass_total = csr_wdata[rdws_pkg::PASS_W-1:0];
            end
            rdws_pkg::CSR_START_DELAY: begin
               cfg_in.start_delay = csr_wdata[rdws_pkg::DELAY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pass_total  <= rdws_pkg::PASS_TOTAL_RST;
         cfg_ff.start_delay <= rdws_pkg::START_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/rdws_step.sv @@
// Search step: next search state and response fields for one request.
`default_nettype none

module rdws_step #(
   parameter int unsigned NUM_CLOCK_SELECTS = 8,
   parameter int unsigned NUM_READ_DELAYS   = 4
) (
   input  wire rdws_pkg::search_state_type          state_cur,
   input  wire rdws_pkg::cfg_type                   cfg,
   input  wire logic                                action,
   input  wire logic [rdws_pkg::HITS_W-1:0]         burst_hits,
   input  wire logic [rdws_pkg::HITS_W-1:0]         valid_count,
   output rdws_pkg::search_state_type               state_nxt,
   output rdws_pkg::result_type                     result
);

   localparam logic [rdws_pkg::SEL_W:0] SEL_LIMIT = (rdws_pkg::SEL_W + 1)'(NUM_CLOCK_SELECTS);

   logic                            pass;
   logic [rdws_pkg::RUN_W-1:0]      run_inc;
   logic [rdws_pkg::SEL_W:0]        sel_inc;
   logic [rdws_pkg::DELAY_W-1:0]    td;
   logic [rdws_pkg::SEL_W-1:0]      ts;

   assign pass = ({1'b0, burst_hits} + {1'b0, valid_count}) == cfg.pass_total;
   assign run_inc = (state_cur.run_length == rdws_pkg::RUN_MAX) ? state_cur.run_length
                                                                : state_cur.run_length + 1'b1;
   assign sel_inc = {1'b0, state_cur.cur_select} + 1'b1;

   always_comb begin
      state_nxt = state_cur;
      if (!action) begin
         state_nxt           = '0;
         state_nxt.cur_delay = rdws_pkg::clamp_delay(cfg.start_delay, NUM_READ_DELAYS);
      end else if (!state_cur.search_done) begin
         if (!pass && state_cur.window_found) begin
            // first failure after a window closes the search
            state_nxt.search_done = 1'b1;
         end else begin
            if (pass) begin
               state_nxt.run_length = run_inc;
               if (run_inc > 1) begin
                  state_nxt.best_delay   = state_cur.cur_delay;
                  state_nxt.best_select  = state_cur.cur_select
                                         - ((run_inc - 1'b1) >> 1);
                  state_nxt.window_found = 1'b1;
               end
            end else begin
               state_nxt.run_length = '0;
            end
            state_nxt.cur_select = sel_inc[rdws_pkg::SEL_W-1:0];
            if (sel_inc >= SEL_LIMIT) begin
               // end of row: finish or step the delay down
               state_nxt.run_length = '0;
               if (state_nxt.window_found || state_cur.cur_delay == '0) begin
                  state_nxt.search_done = 1'b1;
               end else begin
                  state_nxt.cur_delay  = state_cur.cur_delay - 1'b1;
                  state_nxt.cur_select = '0;
               end
            end
         end
      end
   end

   always_comb begin
      if (state_nxt.search_done) begin
         td = state_nxt.window_found ? state_nxt.best_delay  : '0;
         ts = state_nxt.window_found ? state_nxt.best_select : '0;
      end else begin
         td = state_nxt.cur_delay;
         ts = state_nxt.cur_select;
      end
      result.trial_read_delay    = td;
      result.trial_clock_select  = ts[rdws_pkg::SEL_OUT_W-1:0];
      result.timing_word         = rdws_pkg::TIMING_W'({td, 3'b000})
                                 + rdws_pkg::TIMING_W'(ts);
      result.done_res            = state_nxt.search_done;
      result.found               = state_nxt.window_found;
      result.chosen_read_delay   = state_nxt.best_delay;
      result.chosen_clock_select = state_nxt.best_select[rdws_pkg::SEL_OUT_W-1:0];
   end

endmodule

`default_nettype wire

@@ rtl/ddr_read_window_search.sv @@
// Top level of the DDR read window search: request register, search state, response register.
//
//   channel   direction   handshake            payload
//   req_ch    in          valid/ready          action, burst_hits, valid_count
//   rsp_ch    out         valid/ready          trial and chosen settings, status
//   csr_*     in          csr_wr_en            csr_index, csr_wdata
//
// Each request gives one response; it passes through the request register, then the
// response register. One request per cycle is sustained while responses are taken;
// the search state register is updated as a request leaves the request register.
// A stalled response holds; one more request is still taken into the request
// register. Reset is synchronous and restarts the search.
`default_nettype none

module ddr_read_window_search #(
   parameter int unsigned NUM_CLOCK_SELECTS = 8,
   parameter int unsigned NUM_READ_DELAYS   = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rdws_req_if.sink                                req_ch,
   rdws_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_wr_en,
   input  wire logic [rdws_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rdws_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [rdws_pkg::DELAY_W-1:0] RESET_DELAY =
      rdws_pkg::clamp_delay(rdws_pkg::START_DELAY_RST, NUM_READ_DELAYS);
   localparam rdws_pkg::search_state_type STATE_RST =
      '{cur_delay: RESET_DELAY, default: '0};

   rdws_pkg::cfg_type                 cfg;
   rdws_pkg::search_state_type        state_ff;
   rdws_pkg::search_state_type        state_in;
   rdws_pkg::result_type              result_ff;
   rdws_pkg::result_type              result_in;

   logic                              req_valid_ff;
   logic                              req_valid_in;
   logic                              action_ff;
   logic [rdws_pkg::HITS_W-1:0]       hits_ff;
   logic [rdws_pkg::HITS_W-1:0]       valids_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_free;
   logic                              advance;
   logic                              accept;

   rdws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdws_step #(
      .NUM_CLOCK_SELECTS (NUM_CLOCK_SELECTS),
      .NUM_READ_DELAYS   (NUM_READ_DELAYS)
   ) u_step (
      .state_cur   (state_ff),
      .cfg         (cfg),
      .action      (action_ff),
      .burst_hits  (hits_ff),
      .valid_count (valids_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = req_valid_ff && rsp_free;
   assign req_ch.ready = !req_valid_ff || rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_valid_in = accept || (req_valid_ff && !rsp_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RST;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // payload registers: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_ch.action;
         hits_ff   <= req_ch.burst_hits;
         valids_ff <= req_ch.valid_count;
      end
      if (advance) result_ff <= result_in;
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.trial_read_delay    = result_ff.trial_read_delay;
   assign rsp_ch.trial_clock_select  = result_ff.trial_clock_select;
   assign rsp_ch.timing_word         = result_ff.timing_word;
   assign rsp_ch.done_res            = result_ff.done_res;
   assign rsp_ch.found               = result_ff.found;
   assign rsp_ch.chosen_read_delay   = result_ff.chosen_read_delay;
   assign rsp_ch.chosen_clock_select = result_ff.chosen_clock_select;

endmodule

`default_nettype wire

@@ rtl/rdws_checker.sv @@
// Port-level checks on the response channel of the DDR read window search.
`default_nettype none

module rdws_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [rdws_pkg::DELAY_W-1:0]       trial_read_delay,
   input  wire logic [rdws_pkg::SEL_OUT_W-1:0]     trial_clock_select,
   input  wire logic [rdws_pkg::TIMING_W-1:0]      timing_word,
   input  wire logic                               done_res,
   input  wire logic                               found,
   input  wire logic [rdws_pkg::DELAY_W-1:0]       chosen_read_delay,
   input  wire logic [rdws_pkg::SEL_OUT_W-1:0]     chosen_clock_select
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(timing_word) && $stable(done_res)
         && $stable(found) && $stable(chosen_clock_select))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> timing_word[rdws_pkg::SEL_OUT_W-1:0] == trial_clock_select)
      else $error("timing word low bits disagree with clock select");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res && found |->
         trial_read_delay == chosen_read_delay && trial_clock_select == chosen_clock_select)
      else $error("finished search does not present the chosen setting");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res && !found |-> trial_read_delay == '0 && trial_clock_select == '0)
      else $error("failed search does not present a zero setting");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> chosen_read_delay == '0 && chosen_clock_select == '0)
      else $error("chosen setting set without a window");

endmodule

bind ddr_read_window_search rdws_checker u_rdws_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .trial_read_delay    (rsp_ch.trial_read_delay),
   .trial_clock_select  (rsp_ch.trial_clock_select),
   .timing_word         (rsp_ch.timing_word),
   .done_res            (rsp_ch.done_res),
   .found               (rsp_ch.found),
   .chosen_read_delay   (rsp_ch.chosen_read_delay),
   .chosen_clock_select (rsp_ch.chosen_clock_select)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for ddr_read_window_search: random and directed calibration trials checked on the fly.
`timescale 1ns / 100ps

module tb_top;

   localparam int SELECTS     = 8;
   localparam int DELAYS      = 4;
   localparam int CYCLE_LIMIT = 100000;

   localparam logic ACT_RESTART = 1'b0;
   localparam logic ACT_REPORT  = 1'b1;

   typedef struct packed {
      logic                        action;
      logic [rdws_pkg::HITS_W-1:0] hits;
      logic [rdws_pkg::HITS_W-1:0] valids;
   } trial_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_wr_en = 1'b0;
   logic [rdws_pkg::CSR_INDEX_W-1:0] csr_index = rdws_pkg::CSR_PASS_TOTAL;
   logic [rdws_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   rdws_req_if req_ch ();
   rdws_rsp_if rsp_ch ();

   ddr_read_window_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Search state as the block should hold it, plus its programmed registers.
   logic [rdws_pkg::PASS_W-1:0]  cfg_pass_total  = rdws_pkg::PASS_TOTAL_RST;
   logic [rdws_pkg::DELAY_W-1:0] cfg_start_delay = rdws_pkg::START_DELAY_RST;
   logic [rdws_pkg::DELAY_W-1:0] sr_delay;
   logic [rdws_pkg::SEL_W-1:0]   sr_select;
   logic [rdws_pkg::RUN_W-1:0]   sr_run;
   logic                         sr_found;
   logic [rdws_pkg::DELAY_W-1:0] sr_best_delay;
   logic [rdws_pkg::SEL_W-1:0]   sr_best_select;
   logic                         sr_done;

   trial_type            trial_backlog[$];
   rdws_pkg::result_type predicted_settings[$];

   int send_idle_pct     = 0;
   int recv_stall_pct    = 0;
   int errors            = 0;
   int requests_sent     = 0;
   int responses_checked = 0;
   int windows_found     = 0;
   int searches_failed   = 0;
   int phases_run        = 0;
   int cycle_count       = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic void restart_search();
      sr_delay = (int'(cfg_start_delay) >= DELAYS) ? rdws_pkg::DELAY_W'(DELAYS - 1)
                                                   : cfg_start_delay;
      sr_select      = '0;
      sr_run         = '0;
      sr_found       = 1'b0;
      sr_best_delay  = '0;
      sr_best_select = '0;
      sr_done        = 1'b0;
   endfunction

   // Advance the search by one request and return the settings it should answer with.
   function automatic rdws_pkg::result_type search_step(input logic act,
         input logic [rdws_pkg::HITS_W-1:0] hits, input logic [rdws_pkg::HITS_W-1:0] valids);
      rdws_pkg::result_type         r;
      logic [rdws_pkg::DELAY_W-1:0] td;
      logic [rdws_pkg::SEL_W-1:0]   ts;
      logic                         advance;
      advance = 1'b1;
      if (act == ACT_RESTART) begin
         restart_search();
      end else if (!sr_done) begin
         if (rdws_pkg::PASS_W'(hits) + rdws_pkg::PASS_W'(valids) == cfg_pass_total) begin
            if (sr_run < rdws_pkg::RUN_MAX) sr_run++;
            if (sr_run > 1) begin
               sr_best_delay  = sr_delay;
               sr_best_select = sr_select - ((sr_run - 1'b1) >> 1);
               sr_found       = 1'b1;
            end
         end else if (sr_found) begin
            // first miss after a window closes the search
            sr_done = 1'b1;
            advance = 1'b0;
         end else begin
            sr_run = '0;
         end
         if (advance) begin
            sr_select++;
            if (int'(sr_select) >= SELECTS) begin
               sr_run = '0;
               if (sr_found || sr_delay == 0) begin
                  sr_done = 1'b1;
               end else begin
                  sr_delay--;
                  sr_select = '0;
               end
            end
         end
      end
      if (sr_done) begin
         td = sr_found ? sr_best_delay : '0;
         ts = sr_found ? sr_best_select : '0;
      end else begin
         td = sr_delay;
         ts = sr_select;
      end
      r.trial_read_delay    = td;
      r.trial_clock_select  = ts[rdws_pkg::SEL_OUT_W-1:0];
      r.timing_word         = rdws_pkg::TIMING_W'(int'(td) * 8 + int'(ts));
      r.done_res            = sr_done;
      r.found               = sr_found;
      r.chosen_read_delay   = sr_best_delay;
      r.chosen_clock_select = sr_best_select[rdws_pkg::SEL_OUT_W-1:0];
      return r;
   endfunction

   // Request driver.
   always @(posedge clock) begin : drive_requests
      trial_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predicted_settings.push_back(search_step(req_ch.action, req_ch.burst_hits,
                                                     req_ch.valid_count));
            requests_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (trial_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = trial_backlog.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.action      <= nxt.action;
               req_ch.burst_hits  <= nxt.hits;
               req_ch.valid_count <= nxt.valids;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin : watch_responses
      rdws_pkg::result_type got;
      rdws_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.trial_read_delay    = rsp_ch.trial_read_delay;
         got.trial_clock_select  = rsp_ch.trial_clock_select;
         got.timing_word         = rsp_ch.timing_word;
         got.done_res            = rsp_ch.done_res;
         got.found               = rsp_ch.found;
         got.chosen_read_delay   = rsp_ch.chosen_read_delay;
         got.chosen_clock_select = rsp_ch.chosen_clock_select;
         if (predicted_settings.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = predicted_settings.pop_front();
            responses_checked++;
            if (want.done_res && want.found) windows_found++;
            if (want.done_res && !want.found) searches_failed++;
            check_field("trial_read_delay", got.trial_read_delay, want.trial_read_delay);
            check_field("trial_clock_select", got.trial_clock_select,
                        want.trial_clock_select);
            check_field("timing_word", got.timing_word, want.timing_word);
            check_field("done_res", got.done_res, want.done_res);
            check_field("found", got.found, want.found);
            check_field("chosen_read_delay", got.chosen_read_delay, want.chosen_read_delay);
            check_field("chosen_clock_select", got.chosen_clock_select,
                        want.chosen_clock_select);
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  predicted_settings.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic queue_trial(input logic act, input int hits, input int valids);
      trial_type t;
      t.action = act;
      t.hits   = rdws_pkg::HITS_W'(hits);
      t.valids = rdws_pkg::HITS_W'(valids);
      trial_backlog.push_back(t);
   endtask

   // Queue a report that passes or misses under the current pass total (above 2 * 255 it always misses).
   task automatic queue_report(input bit pass);
      int pt;
      int h;
      int v;
      pt = int'(cfg_pass_total);
      if (pt <= 2 * 255 && ($urandom_range(3) == 0 || pass)) begin
         h = $urandom_range((pt < 255) ? pt : 255, (pt > 255) ? pt - 255 : 0);
         v = pt - h;
         // flip the lowest bit for a near miss
         if (!pass) v = v ^ 1;
      end else begin
         h = $urandom_range(255);
         v = $urandom_range(255);
         if (!pass && h + v == pt) v = v ^ 1;
      end
      queue_trial(ACT_REPORT, h, v);
   endtask

   // One calibration pass: restart, then rows that each may hold a random passing window.
   task automatic queue_search();
      int rows;
      int ws;
      int wl;
      bit closed;
      closed = 1'b0;
      queue_trial(ACT_RESTART, $urandom_range(255), $urandom_range(255));
      rows = $urandom_range(4, 1);
      for (int r = 0; r < rows && !closed; r++) begin
         ws = $urandom_range(SELECTS - 1);
         wl = ($urandom_range(3) == 0) ? 0 : $urandom_range(SELECTS + 1);
         for (int s = 0; s < SELECTS && !closed; s++) begin
            if ($urandom_range(24) == 0)
               queue_trial($urandom_range(1), $urandom_range(255), $urandom_range(255));
            queue_report(s >= ws && s < ws + wl);
            if (wl >= 2 && s >= ws + wl) closed = 1'b1;
         end
      end
      repeat ($urandom_range(2)) queue_report($urandom_range(1));
   endtask

   task automatic queue_random(input int count);
      int target;
      target = trial_backlog.size() + count;
      // stray reports continue whatever search the last phase left
      queue_report($urandom_range(1));
      queue_report($urandom_range(1));
      while (trial_backlog.size() < target) queue_search();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (trial_backlog.size() != 0 || req_ch.valid || predicted_settings.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_phase(input int pt, input int start, input int idle, input int stall);
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= rdws_pkg::CSR_PASS_TOTAL;
      csr_wdata <= rdws_pkg::CSR_DATA_W'(pt);
      @(posedge clock);
      csr_index <= rdws_pkg::CSR_START_DELAY;
      csr_wdata <= {7'($urandom), 2'(start)};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_pass_total  = rdws_pkg::PASS_W'(pt);
      cfg_start_delay = rdws_pkg::DELAY_W'(start);
      send_idle_pct   = idle;
      recv_stall_pct  = stall;
      phases_run++;
      @(negedge clock);
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_RESTART;
      req_ch.burst_hits  = '0;
      req_ch.valid_count = '0;
      rsp_ch.ready       = 1'b0;
      restart_search();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: window in the top row, then a window closed by the row end.
      set_phase(rdws_pkg::PASS_TOTAL_RST, rdws_pkg::START_DELAY_RST, 0, 0);
      queue_trial(ACT_RESTART, 0, 0);
      queue_trial(ACT_REPORT, 0, 0);
      queue_trial(ACT_REPORT, 255, 105);
      queue_trial(ACT_REPORT, 105, 255);
      queue_trial(ACT_REPORT, 180, 180);
      queue_trial(ACT_REPORT, 200, 160);
      queue_trial(ACT_REPORT, 255, 255);
      queue_trial(ACT_REPORT, 0, 0);
      queue_trial(ACT_RESTART, 255, 255);
      queue_trial(ACT_REPORT, 104, 255);
      queue_trial(ACT_REPORT, 255, 106);
      queue_trial(ACT_REPORT, 0, 0);
      queue_trial(ACT_REPORT, 255, 255);
      queue_trial(ACT_REPORT, 1, 2);
      queue_trial(ACT_REPORT, 128, 128);
      queue_trial(ACT_REPORT, 150, 210);
      queue_trial(ACT_REPORT, 210, 150);
      queue_trial(ACT_REPORT, 17, 33);
      queue_random(90);

      // Zero pass total from delay 0: exhaust the only row, then random.
      set_phase(0, 0, 47, 0);
      queue_trial(ACT_RESTART, 0, 0);
      repeat (SELECTS + 1) queue_report(1'b0);
      queue_random(90);

      set_phase((1 << rdws_pkg::PASS_W) - 1, 2, 0, 47);
      queue_random(70);

      set_phase(2 * 255, 1, 35, 35);
      queue_random(100);

      // Hold the sender mid-phase until every response is back.
      set_phase($urandom_range(420, 100), 3, 0, 0);
      queue_random(60);
      wait_drained();
      queue_random(60);

      set_phase(rdws_pkg::PASS_TOTAL_RST, 2, 35, 35);
      queue_random(100);

      wait_drained();
      repeat (8) @(posedge clock);
      if (predicted_settings.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", predicted_settings.size()));
      $display("%0d requests over %0d register settings, %0d responses checked",
               requests_sent, phases_run, responses_checked);
      $display("responses after a found window: %0d, after a failed search: %0d, errors: %0d",
               windows_found, searches_failed, errors);
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
